[sv/kda_pkg.sv]
// kda_pkg: shared types, constants and helpers for the keypad debounce
// and auto-repeat block. No dependencies.
package kda_pkg;

  localparam int unsigned KeyCount   = 16;
  localparam int unsigned MaskWidth  = 16;
  localparam int unsigned IndexWidth = 5;
  localparam int unsigned CfgIdxWidth  = 2;
  localparam int unsigned CfgDataWidth = 16;

  // scan covers keys below KeyCount, never beyond the 16-bit mask
  localparam int unsigned ScanBits = (KeyCount < MaskWidth) ? KeyCount : MaskWidth;

  typedef enum logic [CfgIdxWidth-1:0] {
    CfgPressTicks   = 2'd0,
    CfgRepeatStart  = 2'd1,
    CfgRepeatPeriod = 2'd2,
    CfgUnused       = 2'd3
  } cfg_idx_e;

  localparam logic [3:0]  PressTicksRst   = 4'd10;
  localparam logic [15:0] RepeatStartRst  = 16'd1000;
  localparam logic [4:0]  RepeatPeriodRst = 5'd8;

  localparam logic [4:0] DebounceCap = 5'd15;

  typedef struct packed {
    logic [3:0]  press_ticks;
    logic [15:0] repeat_start;
    logic [4:0]  repeat_period_log2;
  } cfg_t;

  typedef struct packed {
    logic                  valid;
    logic [IndexWidth-1:0] key_index;
  } res_t;

  // one-based index of the lowest pressed key, zero when none in range
  function automatic logic [IndexWidth-1:0] lowest_key(logic [MaskWidth-1:0] mask);
    logic [IndexWidth-1:0] idx;
    idx = '0;
    for (int i = int'(ScanBits) - 1; i >= 0; i--) begin
      if (mask[i]) begin
        idx = IndexWidth'(i + 1);
      end
    end
    return idx;
  endfunction

endpackage

[sv/kda_if.sv]
// kda_if: valid/ready channel interfaces for scan items and key reports.
// Depends on kda_pkg for field widths.
interface kda_in_if;
  logic                         valid;
  logic                         ready;
  logic [kda_pkg::MaskWidth-1:0] first_sample;
  logic [kda_pkg::MaskWidth-1:0] second_sample;

  modport source (output valid, output first_sample, output second_sample, input ready);
  modport sink (input valid, input first_sample, input second_sample, output ready);
endinterface

interface kda_out_if;
  logic                          valid;
  logic                          ready;
  logic [kda_pkg::IndexWidth-1:0] key_index;

  modport source (output valid, output key_index, input ready);
  modport sink (input valid, input key_index, output ready);
endinterface

[sv/keypad_debounce_autorepeat.sv]
// keypad_debounce_autorepeat: top level, input stage and result register.
// Depends on kda_pkg, kda_if, kda_cfg and kda_track.
//
// Debounced keypad scanner with auto repeat. Each input item is one scan
// tick carrying two 16-bit key masks. A key report (one-based index of the
// lowest pressed key) comes out after press_ticks stable ticks, then repeats
// every 2**repeat_period_log2 ticks once the hold count passes repeat_start.
// The block takes one item per clock unless the result register stalls;
// each item passes through the input register, then the state update into
// the result register. Ticks that report nothing leave no result item.
// Input ready drops only while the result register holds an item that
// downstream has not taken. The user writes configuration through the plain
// write port only while no items are in flight, unchecked by the block.
module keypad_debounce_autorepeat (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  kda_in_if.sink                            in_ch,
  kda_out_if.source                         out_ch,
  input  logic                              cfg_we_i,
  input  logic [kda_pkg::CfgIdxWidth-1:0]  cfg_idx_i,
  input  logic [kda_pkg::CfgDataWidth-1:0] cfg_wdata_i
);

  kda_pkg::cfg_t cfg;
  kda_pkg::res_t res;

  // input stage
  logic                          s1_valid_q;
  logic [kda_pkg::MaskWidth-1:0] s1_first_q;
  logic [kda_pkg::MaskWidth-1:0] s1_second_q;

  // result register
  logic                           out_valid_q;
  logic [kda_pkg::IndexWidth-1:0] out_key_q;

  logic step;
  logic in_take;

  // the staged tick is processed whenever the result slot is free or draining
  assign step     = s1_valid_q && (!out_valid_q || out_ch.ready);
  assign in_ch.ready = !s1_valid_q || step;
  assign in_take  = in_ch.valid && in_ch.ready;

  kda_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  kda_track u_track (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .first_i  (s1_first_q),
    .second_i (s1_second_q),
    .cfg_i    (cfg),
    .res_o    (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_take) begin
      s1_valid_q <= 1'b1;
    end else if (step) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_first_q  <= in_ch.first_sample;
      s1_second_q <= in_ch.second_sample;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= res.valid;
    end else if (out_ch.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_key_q <= res.key_index;
    end
  end

  assign out_ch.valid     = out_valid_q;
  assign out_ch.key_index = out_key_q;

endmodule

[sv/kda_cfg.sv]
// kda_cfg: configuration registers behind a plain write port.
// Depends on kda_pkg.
module kda_cfg (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [kda_pkg::CfgIdxWidth-1:0]  cfg_idx_i,
  input  logic [kda_pkg::CfgDataWidth-1:0] cfg_wdata_i,
  output kda_pkg::cfg_t                     cfg_o
);

  kda_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (kda_pkg::cfg_idx_e'(cfg_idx_i))
        kda_pkg::CfgPressTicks:   cfg_d.press_ticks        = cfg_wdata_i[3:0];
        kda_pkg::CfgRepeatStart:  cfg_d.repeat_start       = cfg_wdata_i[15:0];
        kda_pkg::CfgRepeatPeriod: cfg_d.repeat_period_log2 = cfg_wdata_i[4:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.press_ticks        <= kda_pkg::PressTicksRst;
      cfg_q.repeat_start       <= kda_pkg::RepeatStartRst;
      cfg_q.repeat_period_log2 <= kda_pkg::RepeatPeriodRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[sv/kda_track.sv]
// kda_track: key state (last mask, debounce and hold counts) and the
// per-tick report decision. Depends on kda_pkg.
module kda_track (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            step_i,
  input  logic [kda_pkg::MaskWidth-1:0]  first_i,
  input  logic [kda_pkg::MaskWidth-1:0]  second_i,
  input  kda_pkg::cfg_t                   cfg_i,
  output kda_pkg::res_t                   res_o
);

  logic [kda_pkg::MaskWidth-1:0] last_q, last_d;
  logic [3:0]                    deb_q, deb_d;
  logic [31:0]                   hold_q, hold_d;

  logic [4:0]  limit;
  logic [31:0] hold_base;
  logic [31:0] period_mask;
  logic        report;

  always_comb begin
    last_d    = last_q;
    deb_d     = deb_q;
    hold_d    = hold_q;
    report    = 1'b0;
    limit     = {1'b0, cfg_i.press_ticks} + 5'd1;
    if (limit > kda_pkg::DebounceCap) begin
      limit = kda_pkg::DebounceCap;
    end
    hold_base   = (second_i != last_q) ? 32'd0 : hold_q;
    period_mask = (32'd1 << cfg_i.repeat_period_log2) - 32'd1;

    if (first_i != last_q) begin
      // mask changed: restart debounce on the new pattern
      last_d = first_i;
      deb_d  = '0;
      hold_d = '0;
    end else if (second_i == '0) begin
      last_d = '0;
      deb_d  = '0;
      hold_d = '0;
    end else begin
      if ({1'b0, deb_q} < limit) begin
        deb_d = deb_q + 4'd1;
      end
      hold_d = hold_base + 32'd1;
      if (deb_d == cfg_i.press_ticks) begin
        report = 1'b1;
      end else if (deb_d > cfg_i.press_ticks &&
                   hold_d > {16'd0, cfg_i.repeat_start} &&
                   (hold_d & period_mask) == 32'd0) begin
        report = 1'b1;
      end
    end

    res_o.key_index = kda_pkg::lowest_key(second_i);
    res_o.valid     = report && (res_o.key_index != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= '0;
      deb_q  <= '0;
      hold_q <= '0;
    end else if (step_i) begin
      last_q <= last_d;
      deb_q  <= deb_d;
      hold_q <= hold_d;
    end
  end

endmodule

[sv/kda_checker.sv]
// kda_checker: port-level assertions for keypad_debounce_autorepeat, with
// the bind that attaches it. Depends on kda_pkg.
module kda_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [kda_pkg::IndexWidth-1:0] key_index
);

  // a report always names a key in range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (key_index != '0 && key_index <= kda_pkg::IndexWidth'(kda_pkg::ScanBits)))
    else $error("key index out of range");

  // input stalls only behind a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled without output backpressure");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_ready) |=> $stable(key_index))
    else $error("result changed while stalled");

endmodule

bind keypad_debounce_autorepeat kda_checker u_kda_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .key_index (out_ch.key_index)
);
